/* rtl/core/sre_pkg.sv */
`timescale 1ns / 1ps

package sre_pkg;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  addr_type;

   localparam int DIGEST_WORDS = 5;
   localparam int MSG_WORDS    = 16;
   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = $clog2(ROUNDS);

   typedef logic [ROUND_W-1:0] round_type;

   localparam addr_type ADDR_CONTROL   = 6'd0;
   localparam addr_type ADDR_RESET     = 6'd1;
   localparam addr_type ADDR_STATUS    = 6'd2;
   localparam addr_type ADDR_DIGEST    = 6'd8;
   localparam addr_type ADDR_DIGEST_HI = 6'd12;
   localparam addr_type ADDR_MESSAGE   = 6'd16;
   localparam addr_type ADDR_MESSAGE_HI = 6'd31;
   localparam addr_type ADDR_DMA_MODE  = 6'd32;
   localparam addr_type ADDR_DMA_ADDR  = 6'd33;
   localparam addr_type ADDR_DMA_COUNT = 6'd35;

   localparam int CTRL_START_BIT    = 1;
   localparam int CTRL_IRQ_EN_BIT   = 2;
   localparam int CTRL_CONTINUE_BIT = 3;
   localparam int STATUS_CLEAR_BIT  = 0;
   localparam int DMA_SELECT_BIT    = 0;

   localparam word_type CTRL_STORE_MASK = ~32'h3;

   localparam word_type H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam word_type K_ROUND0 = 32'h5a827999;
   localparam word_type K_ROUND1 = 32'h6ed9eba1;
   localparam word_type K_ROUND2 = 32'h8f1bbcdc;
   localparam word_type K_ROUND3 = 32'hca62c1d6;

   function automatic word_type swap32(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

/* rtl/core/sre_round_core.sv */
`timescale 1ns / 1ps

module sre_round_core
   import sre_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type h_init [DIGEST_WORDS],
   input  word_type msg    [MSG_WORDS],
   output logic     done,
   output word_type work   [DIGEST_WORDS]
);

   typedef enum logic [1:0] {
      CORE_IDLE = 2'b01,
      CORE_RUN  = 2'b10
   } core_state_type;

   core_state_type state_ff, state_in;
   round_type      round_ff, round_in;
   logic           done_ff, done_in;
   word_type       work_ff [DIGEST_WORDS];
   word_type       win_ff  [MSG_WORDS];

   word_type f_val, k_val, t_val, sched, mix;
   logic     load, run;

   always_comb begin
      if (round_ff < round_type'(20)) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K_ROUND0;
      end else if (round_ff < round_type'(40)) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_ROUND1;
      end else if (round_ff < round_type'(60)) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = K_ROUND2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_ROUND3;
      end
      t_val = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val + win_ff[0];
      // window slot j holds w[t+j]; the new tail is w[t+16]
      mix   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      sched = {mix[30:0], mix[31]};
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      done_in  = 1'b0;
      load     = 1'b0;
      run      = 1'b0;
      case (state_ff)
         CORE_IDLE: begin
            if (start) begin
               load     = 1'b1;
               round_in = '0;
               state_in = CORE_RUN;
            end
         end
         CORE_RUN: begin
            run      = 1'b1;
            round_in = round_ff + round_type'(1);
            if (round_ff == round_type'(ROUNDS - 1)) begin
               done_in  = 1'b1;
               state_in = CORE_IDLE;
            end
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < DIGEST_WORDS; i++) work_ff[i] <= h_init[i];
         for (int i = 0; i < MSG_WORDS; i++) win_ff[i] <= swap32(msg[i]);
      end else if (run) begin
         work_ff[0] <= t_val;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= {work_ff[1][1:0], work_ff[1][31:2]};
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3];
         for (int i = 0; i < MSG_WORDS - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[MSG_WORDS-1] <= sched;
      end
   end

   assign done = done_ff;
   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) work[i] = work_ff[i];
   end

endmodule

/* rtl/core/sha1_register_engine.sv */
`timescale 1ns / 1ps
// SHA-1 engine behind a bank of 32-bit word registers.
// Request channel (req_*): one bus access per request, opcode 0 read / 1 write,
// word_addr = byte offset / 4, write_data for writes. Response channel (rsp_*):
// one response per request with read_data (zero on writes and unmapped reads)
// and irq = status done AND control interrupt enable, after the access.
// Plain accesses respond the cycle after acceptance, so back-to-back accesses
// run at one per cycle while the receiver keeps up.
// A control write with start set (and DMA not selected) loads the round unit
// for one cycle, runs 80 rounds at one round per cycle, then adds the working
// words into the digest in the finish state once the output register is free,
// which also gives the response. req_ready stays low for the whole compression.
// A start with DMA selected only stores the control word and responds at once.
// Reset (the reset port or a write to the reset register) restores digest to
// the SHA-1 initial value and clears all other registers.
// When the receiver stalls, the response is held in the output register and
// req_ready drops until it is taken.

module sha1_register_engine
   import sre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [5:0]  req_word_addr,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_HASH   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   word_type  control_ff, control_in;
   logic      done_ff, done_in;
   word_type  msg_ff [MSG_WORDS];
   word_type  msg_in [MSG_WORDS];
   word_type  dig_ff [DIGEST_WORDS];
   word_type  dig_in [DIGEST_WORDS];
   word_type  dma_mode_ff, dma_mode_in;
   word_type  dma_addr_ff, dma_addr_in;
   word_type  dma_count_ff, dma_count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_data_ff, rsp_data_in;
   logic      rsp_irq_ff, rsp_irq_in;

   logic     out_free, req_fire, core_start, core_done;
   word_type rd;
   word_type hash_h    [DIGEST_WORDS];
   word_type core_work [DIGEST_WORDS];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++)
         hash_h[i] = req_write_data[CTRL_CONTINUE_BIT] ? dig_ff[i] : H_INIT[i];
   end

   sre_round_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (core_start),
      .h_init (hash_h),
      .msg    (msg_ff),
      .done   (core_done),
      .work   (core_work)
   );

   always_comb begin
      rd = '0;
      if (req_word_addr == ADDR_CONTROL)
         rd = control_ff;
      else if (req_word_addr == ADDR_STATUS)
         rd = word_type'(done_ff);
      else if (req_word_addr inside {[ADDR_DIGEST:ADDR_DIGEST_HI]})
         rd = swap32(dig_ff[req_word_addr[2:0]]);
      else if (req_word_addr inside {[ADDR_MESSAGE:ADDR_MESSAGE_HI]})
         rd = msg_ff[req_word_addr[3:0]];
      else if (req_word_addr == ADDR_DMA_MODE)
         rd = dma_mode_ff;
      else if (req_word_addr == ADDR_DMA_ADDR)
         rd = dma_addr_ff;
      else if (req_word_addr == ADDR_DMA_COUNT)
         rd = dma_count_ff;
   end

   always_comb begin
      state_in     = state_ff;
      control_in   = control_ff;
      done_in      = done_ff;
      msg_in       = msg_ff;
      dig_in       = dig_ff;
      dma_mode_in  = dma_mode_ff;
      dma_addr_in  = dma_addr_ff;
      dma_count_in = dma_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;
      core_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode) begin
                  if (req_word_addr == ADDR_CONTROL) begin
                     control_in = req_write_data & CTRL_STORE_MASK;
                     if (req_write_data[CTRL_START_BIT] && !dma_mode_ff[DMA_SELECT_BIT]) begin
                        core_start = 1'b1;
                        dig_in     = hash_h;
                        state_in   = ST_HASH;
                     end
                  end else if (req_word_addr == ADDR_RESET) begin
                     control_in   = '0;
                     done_in      = 1'b0;
                     for (int i = 0; i < MSG_WORDS; i++) msg_in[i] = '0;
                     dig_in       = H_INIT;
                     dma_mode_in  = '0;
                     dma_addr_in  = '0;
                     dma_count_in = '0;
                  end else if (req_word_addr == ADDR_STATUS) begin
                     if (req_write_data[STATUS_CLEAR_BIT]) done_in = 1'b0;
                  end else if (req_word_addr inside {[ADDR_DIGEST:ADDR_DIGEST_HI]}) begin
                     dig_in[req_word_addr[2:0]] = swap32(req_write_data);
                  end else if (req_word_addr inside {[ADDR_MESSAGE:ADDR_MESSAGE_HI]}) begin
                     msg_in[req_word_addr[3:0]] = req_write_data;
                  end else if (req_word_addr == ADDR_DMA_MODE) begin
                     dma_mode_in = req_write_data;
                  end else if (req_word_addr == ADDR_DMA_ADDR) begin
                     dma_addr_in = req_write_data;
                  end else if (req_word_addr == ADDR_DMA_COUNT) begin
                     dma_count_in = req_write_data;
                  end
               end
               // a started compression answers from the finish state
               if (!core_start) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = req_opcode ? '0 : rd;
                  rsp_irq_in   = done_in && control_in[CTRL_IRQ_EN_BIT];
               end
            end
         end
         ST_HASH: begin
            if (core_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               for (int i = 0; i < DIGEST_WORDS; i++) dig_in[i] = dig_ff[i] + core_work[i];
               done_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_irq_in   = control_ff[CTRL_IRQ_EN_BIT];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         control_ff   <= '0;
         done_ff      <= 1'b0;
         for (int i = 0; i < MSG_WORDS; i++) msg_ff[i] <= '0;
         dig_ff       <= H_INIT;
         dma_mode_ff  <= '0;
         dma_addr_ff  <= '0;
         dma_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         control_ff   <= control_in;
         done_ff      <= done_in;
         msg_ff       <= msg_in;
         dig_ff       <= dig_in;
         dma_mode_ff  <= dma_mode_in;
         dma_addr_ff  <= dma_addr_in;
         dma_count_ff <= dma_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq       = rsp_irq_ff;

endmodule

/* rtl/core/sre_checker.sv */
`timescale 1ns / 1ps

module sre_checker
   import sre_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_opcode,
   input logic [5:0]  req_word_addr,
   input logic [31:0] req_write_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_irq
);

   logic req_fire, starts;

   assign req_fire = req_valid && req_ready;
   assign starts   = req_opcode && (req_word_addr == ADDR_CONTROL) &&
                     req_write_data[CTRL_START_BIT];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq))
      else $error("stalled response changed");

   a_plain_next: assert property (@(posedge clock) disable iff (reset)
      req_fire && !starts |=> rsp_valid)
      else $error("plain access did not respond next cycle");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid || !req_ready)
      else $error("request taken while previous one neither answered nor busy");

   a_clear_irq: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode && (req_word_addr == ADDR_STATUS) &&
      req_write_data[STATUS_CLEAR_BIT] |=> rsp_valid && !rsp_irq)
      else $error("interrupt still set after status clear");

endmodule

bind sha1_register_engine sre_checker u_sre_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_opcode     (req_opcode),
   .req_word_addr  (req_word_addr),
   .req_write_data (req_write_data),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_data  (rsp_read_data),
   .rsp_irq        (rsp_irq)
);

/* bench/sha1_register_engine_tb.sv */
`timescale 1ns / 1ps

module sha1_register_engine_tb
   import sre_pkg::*;
;

   typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} bus_op_type;

   typedef struct packed {
      bus_op_type op;
      addr_type   addr;
      word_type   data;
   } bus_request_type;

   typedef struct packed {
      bus_op_type op;
      addr_type   addr;
      word_type   read_data;
      logic       irq;
   } bus_response_type;

   localparam word_type CTRL_START    = 32'h1 << CTRL_START_BIT;
   localparam word_type CTRL_IRQ_EN   = 32'h1 << CTRL_IRQ_EN_BIT;
   localparam word_type CTRL_CONTINUE = 32'h1 << CTRL_CONTINUE_BIT;
   localparam word_type STATUS_CLEAR  = 32'h1 << STATUS_CLEAR_BIT;
   localparam word_type DMA_SELECT    = 32'h1 << DMA_SELECT_BIT;
   localparam addr_type ADDR_UNMAPPED = 6'd63;
   localparam addr_type ADDR_GAP      = 6'd34;
   localparam int       HOLD_CYCLES   = 300;
   localparam int       PHASE_ITEMS   = 170;
   localparam int       SETTLE_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [5:0]  req_word_addr = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq;

   // engine state as the bus sees it
   word_type ctrl_reg;
   logic     done_reg;
   word_type msg_reg [MSG_WORDS];
   word_type dig_reg [DIGEST_WORDS];
   word_type dma_mode_reg;
   word_type dma_addr_reg;
   word_type dma_count_reg;

   bus_request_type  request_q[$];
   bus_response_type response_q[$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int phase_items    = 0;

   sha1_register_engine uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_word_addr  (req_word_addr),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq)
   );

   always #5 clock = ~clock;

   function automatic word_type byte_reverse(input word_type v);
      word_type r;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = v[8*(3-i) +: 8];
      end
      return r;
   endfunction

   function automatic word_type rotate_left(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic restore_defaults();
      ctrl_reg = '0;
      done_reg = 1'b0;
      for (int i = 0; i < MSG_WORDS; i++) begin
         msg_reg[i] = '0;
      end
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         dig_reg[i] = H_INIT[i];
      end
      dma_mode_reg  = '0;
      dma_addr_reg  = '0;
      dma_count_reg = '0;
   endtask

   // one SHA-1 block over the stored message, big-endian view of each word
   task automatic hash_block(input logic from_stored);
      word_type sched [80];
      word_type base [DIGEST_WORDS];
      word_type a, b, c, d, e, f, k, t;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         base[i] = from_stored ? dig_reg[i] : H_INIT[i];
      end
      for (int i = 0; i < 16; i++) begin
         sched[i] = byte_reverse(msg_reg[i]);
      end
      for (int i = 16; i < 80; i++) begin
         sched[i] = rotate_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      end
      a = base[0];
      b = base[1];
      c = base[2];
      d = base[3];
      e = base[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = rotate_left(a, 5) + f + e + k + sched[i];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      dig_reg[0] = base[0] + a;
      dig_reg[1] = base[1] + b;
      dig_reg[2] = base[2] + c;
      dig_reg[3] = base[3] + d;
      dig_reg[4] = base[4] + e;
   endtask

   task automatic apply_access(input bus_op_type op, input addr_type addr, input word_type data,
                               output word_type rd, output logic irq);
      rd = '0;
      if (op == OP_READ) begin
         if (addr == ADDR_CONTROL) begin
            rd = ctrl_reg;
         end else if (addr == ADDR_STATUS) begin
            rd = {31'b0, done_reg};
         end else if (addr >= ADDR_DIGEST && addr <= ADDR_DIGEST_HI) begin
            rd = byte_reverse(dig_reg[addr - ADDR_DIGEST]);
         end else if (addr >= ADDR_MESSAGE && addr <= ADDR_MESSAGE_HI) begin
            rd = msg_reg[addr - ADDR_MESSAGE];
         end else if (addr == ADDR_DMA_MODE) begin
            rd = dma_mode_reg;
         end else if (addr == ADDR_DMA_ADDR) begin
            rd = dma_addr_reg;
         end else if (addr == ADDR_DMA_COUNT) begin
            rd = dma_count_reg;
         end
      end else begin
         if (addr == ADDR_CONTROL) begin
            ctrl_reg = data & CTRL_STORE_MASK;
            // DMA start models a failed fetch: control stored, nothing else
            if (data[CTRL_START_BIT] && !dma_mode_reg[DMA_SELECT_BIT]) begin
               hash_block(data[CTRL_CONTINUE_BIT]);
               done_reg = 1'b1;
            end
         end else if (addr == ADDR_RESET) begin
            restore_defaults();
         end else if (addr == ADDR_STATUS) begin
            if (data[STATUS_CLEAR_BIT]) done_reg = 1'b0;
         end else if (addr >= ADDR_DIGEST && addr <= ADDR_DIGEST_HI) begin
            dig_reg[addr - ADDR_DIGEST] = byte_reverse(data);
         end else if (addr >= ADDR_MESSAGE && addr <= ADDR_MESSAGE_HI) begin
            msg_reg[addr - ADDR_MESSAGE] = data;
         end else if (addr == ADDR_DMA_MODE) begin
            dma_mode_reg = data;
         end else if (addr == ADDR_DMA_ADDR) begin
            dma_addr_reg = data;
         end else if (addr == ADDR_DMA_COUNT) begin
            dma_count_reg = data;
         end
      end
      irq = done_reg & ctrl_reg[CTRL_IRQ_EN_BIT];
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic queue_access(input bus_op_type op, input addr_type addr, input word_type data);
      bus_request_type r;
      r.op   = op;
      r.addr = addr;
      r.data = data;
      request_q.push_back(r);
      phase_items++;
   endtask

   // load a block, optionally seed the digest, start, then read the digest and status back
   task automatic queue_hash_sequence();
      logic dma_touched;
      dma_touched = 1'b0;
      if ($urandom_range(3) == 0) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            queue_access(OP_WRITE, addr_type'(ADDR_DIGEST + i), $urandom);
         end
      end
      for (int i = 0; i < MSG_WORDS; i++) begin
         queue_access(OP_WRITE, addr_type'(ADDR_MESSAGE + i), $urandom);
      end
      if ($urandom_range(7) == 0) begin
         queue_access(OP_WRITE, ADDR_DMA_MODE, $urandom);
         dma_touched = 1'b1;
      end
      queue_access(OP_WRITE, ADDR_CONTROL, $urandom | CTRL_START);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         queue_access(OP_READ, addr_type'(ADDR_DIGEST + i), $urandom);
      end
      queue_access(OP_READ, ADDR_STATUS, $urandom);
      if ($urandom_range(1) == 1) queue_access(OP_WRITE, ADDR_STATUS, $urandom);
      if (dma_touched) queue_access(OP_WRITE, ADDR_DMA_MODE, '0);
   endtask

   task automatic queue_noise();
      addr_type a;
      case ($urandom_range(9))
         0: a = ADDR_CONTROL;
         1: a = ($urandom_range(7) == 0) ? ADDR_RESET : ADDR_GAP;
         2: a = ADDR_STATUS;
         3: a = addr_type'(ADDR_DIGEST + $urandom_range(DIGEST_WORDS - 1));
         4: a = addr_type'(ADDR_MESSAGE + $urandom_range(MSG_WORDS - 1));
         5: a = ADDR_DMA_MODE;
         6: a = ADDR_DMA_ADDR;
         7: a = ADDR_DMA_COUNT;
         default: a = addr_type'($urandom_range(63));
      endcase
      queue_access(bus_op_type'($urandom_range(1)), a, $urandom);
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || req_valid || response_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver: predict on acceptance, then hold or present the next request
   always @(posedge clock) begin : drive_proc
      bus_request_type  nxt;
      bus_response_type want;
      word_type         rd;
      logic             irq;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_access(bus_op_type'(req_opcode), req_word_addr, req_write_data, rd, irq);
            want.op        = bus_op_type'(req_opcode);
            want.addr      = req_word_addr;
            want.read_data = rd;
            want.irq       = irq;
            response_q.push_back(want);
         end
         if (req_valid && !req_ready) begin
            // hold the offered request
         end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = request_q.pop_front();
            req_valid      <= 1'b1;
            req_opcode     <= nxt.op;
            req_word_addr  <= nxt.addr;
            req_write_data <= nxt.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // count down a long receiver hold
   always @(posedge clock) begin : hold_proc
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end
   end

   // monitor: check each response, then decide the next ready level
   always @(posedge clock) begin : watch_proc
      bus_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (response_q.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, read_data %h",
                                      rsp_read_data));
         end else begin
            want = response_q.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch($sformatf("op %0d addr %0d read_data %h, want %h",
                                         want.op, want.addr, rsp_read_data, want.read_data));
            if (rsp_irq !== want.irq)
               report_mismatch($sformatf("op %0d addr %0d irq %b, want %b",
                                         want.op, want.addr, rsp_irq, want.irq));
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0 || hold_served != hold_requests) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("sha1_register_engine_tb NOT OK");
      $finish;
   end

   initial begin
      restore_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_access(OP_READ, ADDR_CONTROL, '0);
      queue_access(OP_READ, ADDR_DIGEST, '0);
      queue_access(OP_READ, ADDR_DIGEST_HI, '0);
      queue_access(OP_READ, ADDR_MESSAGE_HI, '0);
      queue_access(OP_READ, ADDR_DMA_COUNT, '0);
      queue_access(OP_READ, ADDR_UNMAPPED, '0);
      queue_access(OP_WRITE, ADDR_MESSAGE, 32'hffffffff);
      queue_access(OP_WRITE, ADDR_MESSAGE_HI, 32'h0);
      // fresh start from the initial value with interrupt enabled
      queue_access(OP_WRITE, ADDR_CONTROL, CTRL_START | CTRL_IRQ_EN);
      queue_access(OP_READ, ADDR_DIGEST, '0);
      // status write without the clear bit leaves done set
      queue_access(OP_WRITE, ADDR_STATUS, ~STATUS_CLEAR);
      queue_access(OP_WRITE, ADDR_CONTROL, 32'hffffffff);
      queue_access(OP_READ, ADDR_STATUS, '0);
      queue_access(OP_WRITE, ADDR_STATUS, STATUS_CLEAR);
      queue_access(OP_READ, ADDR_STATUS, '0);
      // start with DMA selected leaves digest and status alone
      queue_access(OP_WRITE, ADDR_DMA_MODE, DMA_SELECT);
      queue_access(OP_WRITE, ADDR_CONTROL, CTRL_START | CTRL_CONTINUE | CTRL_IRQ_EN);
      queue_access(OP_READ, ADDR_DIGEST_HI, '0);
      queue_access(OP_WRITE, ADDR_DMA_ADDR, 32'hffffffff);
      queue_access(OP_READ, ADDR_DMA_ADDR, '0);
      queue_access(OP_WRITE, ADDR_UNMAPPED, 32'hffffffff);
      queue_access(OP_WRITE, ADDR_RESET, 32'hffffffff);
      queue_access(OP_READ, ADDR_DIGEST, '0);
      queue_access(OP_READ, ADDR_DMA_MODE, '0);
      queue_access(OP_READ, ADDR_CONTROL, '0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         // long receiver hold while requests keep coming
         if (phase == 0 || phase == 3) hold_requests++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(9) < 7) begin
               queue_hash_sequence();
            end else begin
               repeat ($urandom_range(12, 1)) queue_noise();
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (response_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", response_q.size()));
      if (error_count == 0) begin
         $display("sha1_register_engine_tb OK");
      end else begin
         $display("sha1_register_engine_tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/sre_pkg.sv
rtl/core/sre_round_core.sv
rtl/core/sha1_register_engine.sv
rtl/core/sre_checker.sv
bench/sha1_register_engine_tb.sv
